>>> design/chrl_pkg.sv
// Shared types, codes and defaults for the consistent hash ring lookup block.
package chrl_pkg;

   // Default ring size in points
   localparam int DEFAULT_RING_DEPTH = 4096;

   // Fixed field widths
   localparam int HASH_W   = 32;
   localparam int SERVER_W = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // One ring point as held in memory
   typedef struct packed {
      logic [SERVER_W-1:0] server;
      logic [HASH_W-1:0]   value;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE
   } state_type;

endpackage

>>> design/consistent_hash_ring_lookup.sv
// Top level of the consistent hash ring: sorted point store, insert and lookup sequencer.
//
// Usage: each request transfer on req_ carries one operation in req_tuser and its
// operands in req_tdata. Clear empties the ring, insert places a point after any
// points of equal hash, lookup returns the server of the first point whose hash is
// not below the key, wrapping to the first point. Every request gives exactly one
// response transfer on rsp_ with the status in rsp_tuser.
// Points live in one RAM with a registered read; a binary search over it makes one
// read per cycle, and a lookup responds after the search and a final fetch of the
// chosen point.
// An insert runs its search, then moves each point above the insert position up
// by one read and one write through the single RAM port pair, then places the new
// point and loads its response into the output register.
// Clear, unused codes and error cases respond in the cycle after the transfer.
// One request is worked on at a time; req_tready is low while it is in progress.
// A finished response waits in an output register, and the next request is taken
// while that register is drained by the same cycle's rsp_tready.
// Reset empties the ring and drops any pending response; the RAM needs no clearing
// since only entries below the fill count are read.
module consistent_hash_ring_lookup #(
   parameter int RING_DEPTH = chrl_pkg::DEFAULT_RING_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: point_hash[31:0], point_server[39:32], key_hash[71:40]
   input  logic [71:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: chosen_server[7:0], point_count[20:8], zero pad[23:21]
   output logic [23:0] rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   import chrl_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   // Request fields
   op_type              req_op;
   logic [HASH_W-1:0]   req_point_hash;
   logic [SERVER_W-1:0] req_point_server;
   logic [HASH_W-1:0]   req_key_hash;
   logic                req_fire;

   assign req_op           = op_type'(req_tuser);
   assign req_point_hash   = req_tdata[31:0];
   assign req_point_server = req_tdata[39:32];
   assign req_key_hash     = req_tdata[71:40];
   assign req_fire         = req_tvalid & req_tready;

   // Sequencer and datapath registers
   state_type           state_ff, state_in;
   logic                is_insert_ff, is_insert_in;
   logic [HASH_W-1:0]   key_ff, key_in;
   logic [SERVER_W-1:0] server_ff, server_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SERVER_W-1:0] rsp_server_ff, rsp_server_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_load;

   // RAM port signals
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   entry_type           ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   entry_type           ram_rd_data;
   logic [$bits(entry_type)-1:0] ram_rd_bits;

   assign ram_rd_data = entry_type'(ram_rd_bits);

   // Search step signals
   logic                go_right;
   logic [CNT_W-1:0]    step_lo;
   logic [CNT_W-1:0]    step_hi;
   logic [CNT_W-1:0]    step_mid;
   logic                step_more;
   logic [CNT_W-1:0]    wrap_idx;
   logic [CNT_W-1:0]    idx_dec;
   logic [CNT_W-1:0]    fill_inc;
   logic                ring_full;
   logic                ring_empty;

   // Point count views widened then cut to the response field
   logic [CNT_W+COUNT_W-1:0] fill_wide;
   logic [CNT_W+COUNT_W-1:0] fill_inc_wide;

   assign fill_inc      = fill_ff + CNT_W'(1);
   assign idx_dec       = idx_ff - CNT_W'(1);
   assign fill_wide     = {{COUNT_W{1'b0}}, fill_ff};
   assign fill_inc_wide = {{COUNT_W{1'b0}}, fill_inc};
   assign ring_full     = (fill_ff == CNT_W'(RING_DEPTH));
   assign ring_empty    = (fill_ff == '0);

   chrl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   // One binary search step on the point read for mid
   always_comb begin
      if (is_insert_ff) begin
         go_right = (ram_rd_data.value <= key_ff);
      end else begin
         go_right = (ram_rd_data.value < key_ff);
      end
      step_lo   = go_right ? (mid_ff + CNT_W'(1)) : lo_ff;
      step_hi   = go_right ? hi_ff : mid_ff;
      step_mid  = step_lo + ((step_hi - step_lo) >> 1);
      step_more = (step_lo < step_hi);
      wrap_idx  = (step_lo >= fill_ff) ? '0 : step_lo;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_op == OP_INSERT && !ring_full && ring_empty) begin
                  state_in = ST_PLACE;
               end else if (req_op == OP_INSERT && !ring_full) begin
                  state_in = ST_SEARCH;
               end else if (req_op == OP_LOOKUP && !ring_empty) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEARCH: begin
            priority if (step_more) begin
               state_in = ST_SEARCH;
            end else if (!is_insert_ff) begin
               state_in = ST_FETCH;
            end else if (fill_ff > step_lo) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = (idx_dec > lo_ff) ? ST_SHIFT_RD : ST_PLACE;
         end
         ST_PLACE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and RAM controls
   always_comb begin
      req_tready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            // first probe: mid of [0, fill)
            ram_rd_en   = req_fire;
            ram_rd_addr = IDX_W'(fill_ff >> 1);
         end
         ST_SEARCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = step_more ? step_mid[IDX_W-1:0] : wrap_idx[IDX_W-1:0];
         end
         ST_SHIFT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dec[IDX_W-1:0];
         end
         ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IDX_W-1:0];
            ram_wr_data = ram_rd_data;
         end
         ST_PLACE: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = lo_ff[IDX_W-1:0];
            ram_wr_data.value  = key_ff;
            ram_wr_data.server = server_ff;
         end
         ST_FETCH: begin
            ram_rd_en = 1'b0;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   // Datapath and response next values
   always_comb begin
      is_insert_in  = is_insert_ff;
      key_in        = key_ff;
      server_in     = server_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      rsp_load      = 1'b0;
      rsp_server_in = rsp_server_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // capture operands and open the search window
               is_insert_in  = (req_op == OP_INSERT);
               key_in        = (req_op == OP_INSERT) ? req_point_hash : req_key_hash;
               server_in     = req_point_server;
               lo_in         = '0;
               hi_in         = fill_ff;
               mid_in        = fill_ff >> 1;
               idx_in        = fill_ff;
               rsp_server_in = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = fill_wide[COUNT_W-1:0];
               unique case (req_op)
                  OP_CLEAR: begin
                     fill_in      = '0;
                     rsp_count_in = '0;
                     rsp_load     = 1'b1;
                  end
                  OP_INSERT: begin
                     if (ring_full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_load      = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (ring_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                        rsp_load      = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            lo_in  = step_lo;
            hi_in  = step_hi;
            mid_in = step_mid;
         end
         ST_FETCH: begin
            rsp_server_in = ram_rd_data.server;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = fill_wide[COUNT_W-1:0];
            rsp_load      = 1'b1;
         end
         ST_SHIFT_RD: begin
            idx_in = idx_ff;
         end
         ST_SHIFT_WR: begin
            idx_in = idx_dec;
         end
         ST_PLACE: begin
            fill_in       = fill_inc;
            rsp_server_in = '0;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = fill_inc_wide[COUNT_W-1:0];
            rsp_load      = 1'b1;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      is_insert_ff  <= is_insert_in;
      key_ff        <= key_in;
      server_ff     <= server_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      rsp_server_ff <= rsp_server_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Drive the response channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_server_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Fill never passes the ring size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("ring fill beyond depth");

   // Search window stays inside the filled part of the ring
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff) && (hi_ff <= fill_ff) && (mid_ff < hi_ff))
      else $error("search window out of range");

   // Shift only moves points above the insert position
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_WR) |-> (idx_ff > lo_ff) && (idx_ff <= fill_ff))
      else $error("shift index out of range");

   // A response is loaded only when the output register is free or draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");

endmodule

>>> design/chrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module chrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the consistent hash ring lookup block.
`timescale 1ns / 1ps

module tb;
   import chrl_pkg::*;

   localparam int RING_DEPTH     = DEFAULT_RING_DEPTH;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_SLICE   = 170;

   // One response as the ring should report it
   typedef struct packed {
      logic [SERVER_W-1:0] server;
      status_type          status;
      logic [COUNT_W-1:0]  count;
   } answer_type;

   // One directed request, with a typed answer where it is obvious
   typedef struct packed {
      op_type              op;
      logic [HASH_W-1:0]   point_hash;
      logic [SERVER_W-1:0] point_server;
      logic [HASH_W-1:0]   key_hash;
      bit                  typed;
      answer_type          answer;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   // Mirror of the ring contents
   logic [HASH_W-1:0]   mirror_value  [0:RING_DEPTH-1];
   logic [SERVER_W-1:0] mirror_server [0:RING_DEPTH-1];
   int                  mirror_fill = 0;

   answer_type  due_answers [$];
   row_type     directed_rows [$];
   answer_type  seen_answer;

   int  error_count   = 0;
   int  idle_cycles   = 0;
   int  tx_idle_pct   = 0;
   int  rx_idle_pct   = 0;
   int  hold_left     = 0;
   bit  hold_wanted   = 1'b0;
   bit  hold_done     = 1'b0;
   int  lookups_hit   = 0;
   int  lookups_empty = 0;
   int  inserts_done  = 0;
   int  inserts_full  = 0;
   int  clears_done   = 0;
   int  unused_codes  = 0;
   int  deepest_fill  = 0;

   consistent_hash_ring_lookup #(
      .RING_DEPTH (RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the mirror and return the answer it should give
   function automatic answer_type compute_answer(input op_type op,
                                                 input logic [HASH_W-1:0] point_hash,
                                                 input logic [SERVER_W-1:0] point_server,
                                                 input logic [HASH_W-1:0] key_hash);
      answer_type ans;
      int lo;
      int hi;
      int mid;
      int i;
      ans.server = '0;
      ans.status = STATUS_OK;
      case (op)
         OP_CLEAR: begin
            mirror_fill = 0;
         end
         OP_INSERT: begin
            if (mirror_fill >= RING_DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               // upper bound: land after any equal values
               lo = 0;
               hi = mirror_fill;
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (mirror_value[mid] <= point_hash) lo = mid + 1;
                  else hi = mid;
               end
               for (i = mirror_fill; i > lo; i--) begin
                  mirror_value[i]  = mirror_value[i-1];
                  mirror_server[i] = mirror_server[i-1];
               end
               mirror_value[lo]  = point_hash;
               mirror_server[lo] = point_server;
               mirror_fill++;
            end
         end
         OP_LOOKUP: begin
            if (mirror_fill == 0) begin
               ans.status = STATUS_EMPTY;
            end else begin
               // lower bound, wrapping to the first point past the top
               lo = 0;
               hi = mirror_fill;
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (mirror_value[mid] < key_hash) lo = mid + 1;
                  else hi = mid;
               end
               if (lo >= mirror_fill) lo = 0;
               ans.server = mirror_server[lo];
            end
         end
         default: begin
         end
      endcase
      ans.count = COUNT_W'(mirror_fill);
      return ans;
   endfunction

   // Offer one request, wait for its transfer, then queue the answer
   task automatic send_request(input op_type op, input logic [HASH_W-1:0] point_hash,
                               input logic [SERVER_W-1:0] point_server,
                               input logic [HASH_W-1:0] key_hash,
                               input bit typed, input answer_type typed_answer);
      answer_type ans;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {key_hash, point_server, point_hash};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ans = compute_answer(op, point_hash, point_server, key_hash);
      if (typed) ans = typed_answer;
      due_answers.push_back(ans);
      case (op)
         OP_CLEAR:  clears_done++;
         OP_INSERT: if (ans.status == STATUS_FULL) inserts_full++; else inserts_done++;
         OP_LOOKUP: if (ans.status == STATUS_EMPTY) lookups_empty++; else lookups_hit++;
         default:   unused_codes++;
      endcase
      if (mirror_fill > deepest_fill) deepest_fill = mirror_fill;
   endtask

   // Plain request checked against the mirror only
   task automatic send_checked(input op_type op, input logic [HASH_W-1:0] point_hash,
                               input logic [SERVER_W-1:0] point_server,
                               input logic [HASH_W-1:0] key_hash);
      answer_type none;
      none = '0;
      send_request(op, point_hash, point_server, key_hash, 1'b0, none);
   endtask

   task automatic add_row(input op_type op, input logic [HASH_W-1:0] point_hash,
                          input logic [SERVER_W-1:0] point_server,
                          input logic [HASH_W-1:0] key_hash, input bit typed,
                          input logic [SERVER_W-1:0] server, input status_type status,
                          input logic [COUNT_W-1:0] count);
      row_type row;
      row.op            = op;
      row.point_hash    = point_hash;
      row.point_server  = point_server;
      row.key_hash      = key_hash;
      row.typed         = typed;
      row.answer.server = server;
      row.answer.status = status;
      row.answer.count  = count;
      directed_rows.push_back(row);
   endtask

   // Random request: mostly lookups and inserts, keys often near stored points
   task automatic send_random();
      int                  pick;
      op_type              op;
      logic [HASH_W-1:0]   point_hash;
      logic [HASH_W-1:0]   key_hash;
      logic [SERVER_W-1:0] point_server;
      pick         = $urandom_range(999);
      point_hash   = $urandom;
      key_hash     = $urandom;
      point_server = SERVER_W'($urandom);
      if (pick < 15) op = OP_CLEAR;
      else if (pick < 320) op = OP_INSERT;
      else if (pick < 960) op = OP_LOOKUP;
      else op = OP_NONE;
      pick = $urandom_range(99);
      if (mirror_fill > 0) begin
         if (op == OP_INSERT && pick < 25)
            point_hash = mirror_value[$urandom_range(mirror_fill - 1)];
         if (op == OP_LOOKUP && pick < 30)
            key_hash = mirror_value[$urandom_range(mirror_fill - 1)];
         else if (op == OP_LOOKUP && pick < 40)
            key_hash = mirror_value[$urandom_range(mirror_fill - 1)] + 32'd1;
         else if (op == OP_LOOKUP && pick < 48)
            key_hash = mirror_value[$urandom_range(mirror_fill - 1)] - 32'd1;
      end
      if (pick >= 96) begin
         point_hash = (pick[0]) ? '1 : '0;
         key_hash   = (pick[0]) ? '1 : '0;
      end
      send_checked(op, point_hash, point_server, key_hash);
   endtask

   // Drain responses, with random stalls and one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compare each response transfer with the oldest queued answer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_answer.server = rsp_tdata[7:0];
         seen_answer.status = status_type'(rsp_tuser);
         seen_answer.count  = rsp_tdata[20:8];
         if (due_answers.size() == 0) begin
            $display("%0t: response with nothing awaited: server %0h status %0h count %0d",
                     $realtime, seen_answer.server, rsp_tuser, seen_answer.count);
            error_count++;
         end else begin
            if (due_answers[0].server !== seen_answer.server) begin
               $display("%0t: chosen_server expected %0h actual %0h",
                        $realtime, due_answers[0].server, seen_answer.server);
               error_count++;
            end
            if (due_answers[0].status !== rsp_tuser) begin
               $display("%0t: status expected %0h actual %0h",
                        $realtime, due_answers[0].status, rsp_tuser);
               error_count++;
            end
            if (due_answers[0].count !== seen_answer.count) begin
               $display("%0t: point_count expected %0d actual %0d",
                        $realtime, due_answers[0].count, seen_answer.count);
               error_count++;
            end
            if (rsp_tdata[23:21] !== 3'b000) begin
               $display("%0t: tdata pad expected 0 actual %0h", $realtime, rsp_tdata[23:21]);
               error_count++;
            end
            void'(due_answers.pop_front());
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d answers still awaited",
                     $realtime, WATCHDOG_LIMIT, due_answers.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int          i;
      row_type     row;

      // Extremes, equal points, wrap-around and error cases
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0, 1'b1, 8'h00, STATUS_EMPTY, 13'd0);
      add_row(OP_NONE, '1, '1, '1, 1'b1, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_INSERT, 32'hffff_ffff, 8'hff, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd1);
      add_row(OP_INSERT, 32'h0, 8'h00, 32'hffff_ffff, 1'b1, 8'h00, STATUS_OK, 13'd2);
      add_row(OP_INSERT, 32'h8000_0000, 8'ha5, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd3);
      add_row(OP_INSERT, 32'h8000_0000, 8'h5a, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd4);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'hffff_ffff, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, '1, '1, 32'h8000_0000, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h7fff_ffff, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h8000_0001, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_NONE, 32'h1234_5678, 8'h3c, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd4);
      add_row(OP_CLEAR, 32'h0, 8'h00, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, '1, '1, '1, 1'b1, 8'h00, STATUS_EMPTY, 13'd0);
      add_row(OP_INSERT, 32'h0000_1000, 8'h07, 32'h0, 1'b1, 8'h00, STATUS_OK, 13'd1);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_1001, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'hffff_ffff, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_INSERT, 32'h0000_1000, 8'h08, 32'h0, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_INSERT, 32'h0000_0fff, 8'h09, 32'h0, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_1000, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_0fff, 1'b0, 8'h00, STATUS_OK, 13'd0);
      add_row(OP_CLEAR, '1, '1, '1, 1'b1, 8'h00, STATUS_OK, 13'd0);

      // Hold reset, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily
      tx_idle_pct = 26;
      rx_idle_pct <= 51;
      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         send_request(row.op, row.point_hash, row.point_server, row.key_hash,
                      row.typed, row.answer);
      end
      for (i = 0; i < RANDOM_SLICE; i++) begin
         if (i == 40) hold_wanted <= 1'b1;
         send_random();
      end

      // Swap the idling of the two sides
      tx_idle_pct = 51;
      rx_idle_pct <= 26;
      for (i = 0; i < RANDOM_SLICE; i++) send_random();

      // No idling on either side
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      for (i = 0; i < RANDOM_SLICE; i++) send_random();
      req_tvalid <= 1'b0;

      // Drain outstanding answers, then watch for stray responses
      while (due_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d lookups (%0d on an empty ring), %0d inserts (%0d refused as full)",
               lookups_hit + lookups_empty, lookups_empty, inserts_done + inserts_full,
               inserts_full);
      $display("with %0d clears, %0d unused codes, ring filled up to %0d points",
               clears_done, unused_codes, deepest_fill);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
